/* sv/pit_pkg.sv */
// Shared types and constants for the pedigree IBD tracker.
`default_nettype none

package pit_pkg;

    // Field widths fixed by the item layout
    localparam int ID_W        = 13;
    localparam int IN_ALLELE_W = 13;
    localparam int IDX_OUT_W   = 12;
    localparam int HALVES_W    = 2;

    // Defaults for the top-level parameters
    localparam int MAX_INDIVIDUALS_DEF = 4096;
    localparam int ALLELE_BITS_DEF     = 13;

    // Inbreeding in halves: one half and one whole
    localparam logic [HALVES_W-1:0] FA_HALF = 2'd1;
    localparam logic [HALVES_W-1:0] FA_ONE  = 2'd2;

    typedef struct packed {
        logic                   first_of_pedigree;
        logic [ID_W-1:0]        mother_id;
        logic [ID_W-1:0]        father_id;
        logic [IN_ALLELE_W-1:0] maternal_allele;
        logic [IN_ALLELE_W-1:0] paternal_allele;
    } t_in_item;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] individual_index;
        logic                 ibd_maternal;
        logic                 ibd_paternal;
        logic [HALVES_W-1:0]  inbreeding_halves;
        logic                 order_error;
    } t_out_item;

endpackage

`default_nettype wire

/* sv/pit_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module pit_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/pit_parent.sv */
// Resolves one parent's stored entry into an IBD flag and an inbreeding gain.
`default_nettype none

module pit_parent #(
    parameter int ALLELE_BITS = pit_pkg::ALLELE_BITS_DEF
) (
    input  wire logic                     i_known,
    input  wire logic [2*ALLELE_BITS+3:0] i_entry,
    input  wire logic [ALLELE_BITS-1:0]   i_own,
    output logic                          o_ibd,
    output logic                          o_gain
);

    logic [ALLELE_BITS-1:0]       mat;
    logic [ALLELE_BITS-1:0]       pat;
    logic                         ibd_m;
    logic                         ibd_p;
    logic [pit_pkg::HALVES_W-1:0] fa;
    logic                         hom;
    logic                         via;

    // Entry layout: maternal allele, paternal allele, two IBD flags, halves
    assign mat   = i_entry[2*ALLELE_BITS+3:ALLELE_BITS+4];
    assign pat   = i_entry[ALLELE_BITS+3:4];
    assign ibd_m = i_entry[3];
    assign ibd_p = i_entry[2];
    assign fa    = i_entry[1:0];

    assign hom = (mat == pat);
    assign via = (ibd_m && (i_own == mat)) || (ibd_p && (i_own == pat));

    assign o_ibd  = i_known && (hom || via);
    assign o_gain = i_known && (hom || (fa == pit_pkg::FA_ONE)
                                    || ((fa == pit_pkg::FA_HALF) && via));

endmodule

`default_nettype wire

/* sv/pedigree_ibd_tracker.sv */
// Pedigree IBD tracker: parent lookup in an individual store, result per individual.
//
// Input channel: i_in_valid / o_in_stall with i_in_data. Each transfer is one
// individual in pedigree order; first_of_pedigree restarts numbering at zero.
// Output channel: o_out_valid / i_out_stall with o_out_data, one result per input.
// Each individual reads its mother's and father's entries from the store, which
// has a single read port, so an item holds the lookup stage for a mother read
// (S_MOM) and a father read (S_DAD). The freshly written entry of the previous
// individual is forwarded when the mother read overlaps its write.
// A new individual is taken in S_DAD; results pass the resolve and output registers.
// A stalled output holds its result; the next item can still finish its lookup
// behind it, after which the input side stalls.
// Reset empties the pipeline and clears the individual counter. The store is
// not cleared; only entries written in the current pedigree are ever used.
`default_nettype none

module pedigree_ibd_tracker #(
    parameter int MAX_INDIVIDUALS = pit_pkg::MAX_INDIVIDUALS_DEF,
    parameter int ALLELE_BITS     = pit_pkg::ALLELE_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire pit_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output pit_pkg::t_out_item     o_out_data
);

    localparam int IDX_W = $clog2(MAX_INDIVIDUALS);
    localparam int CNT_W = $clog2(MAX_INDIVIDUALS + 1);
    localparam int CMP_W = (CNT_W > pit_pkg::ID_W) ? CNT_W : pit_pkg::ID_W;
    localparam int ENT_W = 2*ALLELE_BITS + 4;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MOM  = 3'b010,
        S_DAD  = 3'b100
    } t_slot_st;

    // Lookup slot
    t_slot_st               r_st, n_st;
    logic [CNT_W-1:0]       r_a_idx;
    logic [IDX_W-1:0]       r_a_mom_addr;
    logic [IDX_W-1:0]       r_a_dad_addr;
    logic [ALLELE_BITS-1:0] r_a_own_m;
    logic [ALLELE_BITS-1:0] r_a_own_p;
    logic                   r_a_mom_ok;
    logic                   r_a_dad_ok;
    logic                   r_a_err;
    logic                   r_a_store;

    // Resolve stage
    logic                   r_r_vld, n_r_vld;
    logic [CNT_W-1:0]       r_r_idx;
    logic [ALLELE_BITS-1:0] r_r_own_m;
    logic [ALLELE_BITS-1:0] r_r_own_p;
    logic                   r_r_mom_ok;
    logic                   r_r_dad_ok;
    logic                   r_r_err;
    logic                   r_r_store;
    logic [ENT_W-1:0]       r_r_mom_entry;

    // Last write, for the overlapping mother read
    logic                   r_fwd_vld;
    logic [IDX_W-1:0]       r_fwd_addr;
    logic [ENT_W-1:0]       r_fwd_data;

    // Output register
    logic                   r_o_vld, n_o_vld;
    pit_pkg::t_out_item     r_o;

    logic [CNT_W-1:0]       r_next, n_next;

    logic                   in_fire;
    logic                   r_fire;
    logic                   go_mom;
    logic [CNT_W-1:0]       cur_idx;
    logic [CMP_W-1:0]       mid_c;
    logic [CMP_W-1:0]       fid_c;
    logic [CMP_W-1:0]       idx_c;
    logic [CMP_W-1:0]       max_c;
    logic                   mom_ok;
    logic                   dad_ok;
    logic                   mom_err;
    logic                   dad_err;
    logic                   cur_store;

    logic                   ram_re;
    logic [IDX_W-1:0]       ram_raddr;
    logic [ENT_W-1:0]       ram_rdata;
    logic [ENT_W-1:0]       mom_entry;
    logic [ENT_W-1:0]       wr_data;

    logic                   ibd_m;
    logic                   ibd_p;
    logic                   gain_m;
    logic                   gain_p;
    logic [pit_pkg::HALVES_W-1:0] fa_sum;

    // Handshake
    assign o_in_stall  = (r_st == S_MOM);
    assign in_fire     = i_in_valid && !o_in_stall;
    assign r_fire      = r_r_vld && (!r_o_vld || !i_out_stall);
    assign go_mom      = (r_st == S_MOM) && (!r_r_vld || r_fire);
    assign o_out_valid = r_o_vld;
    assign o_out_data  = r_o;

    // Index and parent checks at intake
    assign cur_idx   = i_in_data.first_of_pedigree ? '0 : r_next;
    assign mid_c     = CMP_W'(i_in_data.mother_id);
    assign fid_c     = CMP_W'(i_in_data.father_id);
    assign idx_c     = CMP_W'(cur_idx);
    assign max_c     = CMP_W'(MAX_INDIVIDUALS);
    assign mom_ok    = (mid_c != '0) && (mid_c <= idx_c) && (mid_c <= max_c);
    assign dad_ok    = (fid_c != '0) && (fid_c <= idx_c) && (fid_c <= max_c);
    assign mom_err   = (mid_c != '0) && !mom_ok;
    assign dad_err   = (fid_c != '0) && !dad_ok;
    assign cur_store = (cur_idx < CNT_W'(MAX_INDIVIDUALS));

    always_comb begin
        n_next = r_next;
        if (in_fire) begin
            n_next = cur_store ? cur_idx + CNT_W'(1) : cur_idx;
        end
    end

    always_comb begin
        unique case (r_st)
            S_IDLE:  n_st = in_fire ? S_MOM : S_IDLE;
            S_MOM:   n_st = go_mom ? S_DAD : S_MOM;
            S_DAD:   n_st = in_fire ? S_MOM : S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    assign n_r_vld = (r_st == S_DAD) || (r_r_vld && !r_fire);
    assign n_o_vld = r_fire || (r_o_vld && i_out_stall);

    // Store reads: mother in the last S_MOM cycle, father in S_DAD
    assign ram_re    = go_mom || (r_st == S_DAD);
    assign ram_raddr = (r_st == S_DAD) ? r_a_dad_addr : r_a_mom_addr;

    // Mother read overlapped the previous write: take the written entry
    assign mom_entry = (r_fwd_vld && (r_fwd_addr == r_a_mom_addr)) ? r_fwd_data
                                                                  : ram_rdata;

    pit_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_INDIVIDUALS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_fire && r_r_store),
        .i_waddr (IDX_W'(r_r_idx)),
        .i_wdata (wr_data),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pit_parent #(
        .ALLELE_BITS (ALLELE_BITS)
    ) u_mom (
        .i_known (r_r_mom_ok),
        .i_entry (r_r_mom_entry),
        .i_own   (r_r_own_m),
        .o_ibd   (ibd_m),
        .o_gain  (gain_m)
    );

    // Father data arrives straight from the store in the resolve cycle
    pit_parent #(
        .ALLELE_BITS (ALLELE_BITS)
    ) u_dad (
        .i_known (r_r_dad_ok),
        .i_entry (ram_rdata),
        .i_own   (r_r_own_p),
        .o_ibd   (ibd_p),
        .o_gain  (gain_p)
    );

    assign fa_sum  = pit_pkg::HALVES_W'(gain_m) + pit_pkg::HALVES_W'(gain_p);
    assign wr_data = {r_r_own_m, r_r_own_p, ibd_m, ibd_p, fa_sum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_IDLE;
            r_r_vld   <= 1'b0;
            r_o_vld   <= 1'b0;
            r_fwd_vld <= 1'b0;
            r_next    <= '0;
        end else begin
            r_st      <= n_st;
            r_r_vld   <= n_r_vld;
            r_o_vld   <= n_o_vld;
            r_fwd_vld <= r_fire && r_r_store;
            r_next    <= n_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a_idx      <= cur_idx;
            r_a_mom_addr <= IDX_W'(i_in_data.mother_id - pit_pkg::ID_W'(1));
            r_a_dad_addr <= IDX_W'(i_in_data.father_id - pit_pkg::ID_W'(1));
            r_a_own_m    <= ALLELE_BITS'(i_in_data.maternal_allele);
            r_a_own_p    <= ALLELE_BITS'(i_in_data.paternal_allele);
            r_a_mom_ok   <= mom_ok;
            r_a_dad_ok   <= dad_ok;
            r_a_err      <= mom_err || dad_err;
            r_a_store    <= cur_store;
        end
        if (r_st == S_DAD) begin
            r_r_idx       <= r_a_idx;
            r_r_own_m     <= r_a_own_m;
            r_r_own_p     <= r_a_own_p;
            r_r_mom_ok    <= r_a_mom_ok;
            r_r_dad_ok    <= r_a_dad_ok;
            r_r_err       <= r_a_err;
            r_r_store     <= r_a_store;
            r_r_mom_entry <= mom_entry;
        end
        r_fwd_addr <= IDX_W'(r_r_idx);
        r_fwd_data <= wr_data;
        if (r_fire) begin
            r_o.individual_index  <= pit_pkg::IDX_OUT_W'(r_r_idx);
            r_o.ibd_maternal      <= ibd_m;
            r_o.ibd_paternal      <= ibd_p;
            r_o.inbreeding_halves <= fa_sum;
            r_o.order_error       <= r_r_err;
        end
    end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Testbench for the pedigree IBD tracker: random pedigrees, bad parent ids, per-field checks.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_IND      = pit_pkg::MAX_INDIVIDUALS_DEF;
    localparam int ALLELE_BITS  = pit_pkg::ALLELE_BITS_DEF;
    localparam logic [pit_pkg::IN_ALLELE_W-1:0] ALLELE_MAX = '1;
    localparam int ID_MAX       = (1 << pit_pkg::ID_W) - 1;
    localparam logic [pit_pkg::IN_ALLELE_W-1:0] ALLELE_MASK =
        pit_pkg::IN_ALLELE_W'((1 << ALLELE_BITS) - 1);
    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        pit_pkg::t_in_item item;
        int unsigned       gap;
    } t_offer;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               in_valid  = 1'b0;
    pit_pkg::t_in_item  in_data   = '0;
    logic               in_stall;
    logic               out_valid;
    logic               out_stall = 1'b0;
    pit_pkg::t_out_item out_data;

    always #1 i_clk = ~i_clk;

    pedigree_ibd_tracker u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // Predicted contents of the individual store
    logic [pit_pkg::IN_ALLELE_W-1:0] anc_mat   [MAX_IND];
    logic [pit_pkg::IN_ALLELE_W-1:0] anc_pat   [MAX_IND];
    logic                            anc_ibd_m [MAX_IND];
    logic                            anc_ibd_p [MAX_IND];
    logic [pit_pkg::HALVES_W-1:0]    anc_fa    [MAX_IND];
    int unsigned                     pred_next = 0;

    pit_pkg::t_out_item ibd_expect [$];
    t_offer      pending_items [$];
    int unsigned errors      = 0;
    int unsigned n_sent      = 0;
    int unsigned n_peds      = 0;
    int unsigned n_full      = 0;
    int unsigned n_checked   = 0;
    int unsigned n_order_err = 0;
    int unsigned n_ibd       = 0;
    int unsigned n_inbred    = 0;
    int unsigned tx_wait     = 0;
    int unsigned rx_wait     = 0;
    int unsigned hold_left   = 0;
    bit          hold_done   = 1'b0;
    int unsigned quiet_cycles = 0;

    // Generator's view of the current pedigree, used to pick inherited alleles
    logic [pit_pkg::IN_ALLELE_W-1:0] gen_mat [$];
    logic [pit_pkg::IN_ALLELE_W-1:0] gen_pat [$];
    bit idle_phase = 1'b1;

    function automatic void parent_share(input int unsigned p,
                                         input logic [pit_pkg::IN_ALLELE_W-1:0] own,
                                         output logic ibd, output logic gain);
        logic hom, via_m, via_p;
        hom   = anc_mat[p] == anc_pat[p];
        via_m = anc_ibd_m[p] && (own == anc_mat[p]);
        via_p = anc_ibd_p[p] && (own == anc_pat[p]);
        ibd   = hom || via_m || via_p;
        gain  = hom || (anc_fa[p] == pit_pkg::FA_ONE)
                    || (anc_fa[p] == pit_pkg::FA_HALF && (via_m || via_p));
    endfunction

    function automatic pit_pkg::t_out_item ibd_predict(input pit_pkg::t_in_item it);
        pit_pkg::t_out_item r;
        logic [pit_pkg::IN_ALLELE_W-1:0] own_m, own_p;
        logic ibd, gain;
        int unsigned idx, fa;
        r     = '0;
        fa    = 0;
        own_m = it.maternal_allele & ALLELE_MASK;
        own_p = it.paternal_allele & ALLELE_MASK;
        if (it.first_of_pedigree) pred_next = 0;
        idx = pred_next;
        // A parent that is not an earlier individual counts as unknown
        if (it.mother_id != 0) begin
            if (it.mother_id <= idx && it.mother_id <= MAX_IND) begin
                parent_share(it.mother_id - 1, own_m, ibd, gain);
                r.ibd_maternal = ibd;
                fa += gain;
            end else begin
                r.order_error = 1'b1;
            end
        end
        if (it.father_id != 0) begin
            if (it.father_id <= idx && it.father_id <= MAX_IND) begin
                parent_share(it.father_id - 1, own_p, ibd, gain);
                r.ibd_paternal = ibd;
                fa += gain;
            end else begin
                r.order_error = 1'b1;
            end
        end
        if (idx < MAX_IND) begin
            anc_mat[idx]   = own_m;
            anc_pat[idx]   = own_p;
            anc_ibd_m[idx] = r.ibd_maternal;
            anc_ibd_p[idx] = r.ibd_paternal;
            anc_fa[idx]    = fa[pit_pkg::HALVES_W-1:0];
            pred_next      = idx + 1;
        end else begin
            n_full++;
        end
        r.individual_index  = idx[pit_pkg::IDX_OUT_W-1:0];
        r.inbreeding_halves = fa[pit_pkg::HALVES_W-1:0];
        return r;
    endfunction

    function automatic int unsigned draw_gap();
        if (idle_phase) return $urandom_range(13, 0);
        return 0;
    endfunction

    function automatic logic [pit_pkg::IN_ALLELE_W-1:0] rand_allele();
        case ($urandom_range(3, 0))
            0, 1:    return pit_pkg::IN_ALLELE_W'($urandom_range(7, 0));
            2:       return pit_pkg::IN_ALLELE_W'($urandom_range(ALLELE_MAX, ALLELE_MAX - 7));
            default: return pit_pkg::IN_ALLELE_W'($urandom_range(ALLELE_MAX, 0));
        endcase
    endfunction

    function automatic logic [pit_pkg::IN_ALLELE_W-1:0] inherit(input int unsigned id);
        if (id == 0 || id > gen_mat.size() || $urandom_range(9, 0) == 0) return rand_allele();
        return $urandom_range(1, 0) ? gen_mat[id-1] : gen_pat[id-1];
    endfunction

    // Favor the most recent individuals so the write-to-read forwarding gets hit
    function automatic int unsigned pick_parent(input int unsigned k);
        int unsigned span;
        span = (k < 8) ? k : 8;
        if ($urandom_range(1, 0)) return k - $urandom_range(span - 1, 0);
        return $urandom_range(k, 1);
    endfunction

    task automatic offer(input bit first, input int unsigned mid, input int unsigned fid,
                         input logic [pit_pkg::IN_ALLELE_W-1:0] am,
                         input logic [pit_pkg::IN_ALLELE_W-1:0] ap);
        t_offer o;
        if (first) begin
            gen_mat.delete();
            gen_pat.delete();
        end
        if (gen_mat.size() < MAX_IND) begin
            gen_mat.insert(gen_mat.size(), am);
            gen_pat.insert(gen_pat.size(), ap);
        end
        o.item.first_of_pedigree = first;
        o.item.mother_id         = pit_pkg::ID_W'(mid);
        o.item.father_id         = pit_pkg::ID_W'(fid);
        o.item.maternal_allele   = am;
        o.item.paternal_allele   = ap;
        o.gap                    = draw_gap();
        pending_items.insert(pending_items.size(), o);
    endtask

    task automatic add_member(input bit first, input bit founder);
        int unsigned k, mid, fid;
        logic [pit_pkg::IN_ALLELE_W-1:0] am, ap;
        k = first ? 0 : gen_mat.size();
        if (founder || k == 0) begin
            mid = 0;
            fid = 0;
            am  = rand_allele();
            ap  = ($urandom_range(3, 0) == 0) ? am : rand_allele();
        end else begin
            mid = pick_parent(k);
            fid = pick_parent(k);
            case ($urandom_range(9, 0))
                0:       mid = 0;
                1:       fid = 0;
                default: ;
            endcase
            am = inherit(mid);
            ap = inherit(fid);
        end
        offer(first, mid, fid, am, ap);
    endtask

    task automatic add_noise();
        int unsigned k, mid, fid;
        k   = gen_mat.size();
        mid = $urandom_range(1, 0) ? $urandom_range(ID_MAX, 0) : k + $urandom_range(3, 1);
        fid = $urandom_range(1, 0) ? $urandom_range(ID_MAX, 0) : k + $urandom_range(3, 1);
        offer($urandom_range(15, 0) == 0, mid, fid,
              pit_pkg::IN_ALLELE_W'($urandom_range(ALLELE_MAX, 0)),
              pit_pkg::IN_ALLELE_W'($urandom_range(ALLELE_MAX, 0)));
    endtask

    // Driver: present queued items, hold each until its transfer, then wait its gap
    always @(posedge i_clk) begin : driver
        t_offer nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (in_valid && !in_stall) begin
                ibd_expect.insert(ibd_expect.size(), ibd_predict(in_data));
                n_sent++;
                if (in_data.first_of_pedigree) n_peds++;
            end
            if (!in_valid || !in_stall) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    nxt = pending_items.pop_front();
                    in_data  <= nxt.item;
                    in_valid <= 1'b1;
                    tx_wait = nxt.gap;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer against the oldest prediction
    always @(posedge i_clk) begin : monitor
        pit_pkg::t_out_item want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            rx_wait = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (ibd_expect.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, out_data);
                    errors++;
                end else begin
                    want = ibd_expect.pop_front();
                    if (out_data.individual_index !== want.individual_index) begin
                        $display("%0t: individual_index expected %0d actual %0d", $time,
                                 want.individual_index, out_data.individual_index);
                        errors++;
                    end
                    if (out_data.ibd_maternal !== want.ibd_maternal) begin
                        $display("%0t: ibd_maternal expected %0b actual %0b", $time,
                                 want.ibd_maternal, out_data.ibd_maternal);
                        errors++;
                    end
                    if (out_data.ibd_paternal !== want.ibd_paternal) begin
                        $display("%0t: ibd_paternal expected %0b actual %0b", $time,
                                 want.ibd_paternal, out_data.ibd_paternal);
                        errors++;
                    end
                    if (out_data.inbreeding_halves !== want.inbreeding_halves) begin
                        $display("%0t: inbreeding_halves expected %0d actual %0d", $time,
                                 want.inbreeding_halves, out_data.inbreeding_halves);
                        errors++;
                    end
                    if (out_data.order_error !== want.order_error) begin
                        $display("%0t: order_error expected %0b actual %0b", $time,
                                 want.order_error, out_data.order_error);
                        errors++;
                    end
                    n_order_err += want.order_error;
                    n_ibd       += want.ibd_maternal + want.ibd_paternal;
                    n_inbred    += (want.inbreeding_halves == pit_pkg::FA_ONE);
                end
                n_checked++;
                // One stretch in three runs without random receiver stalls
                rx_wait = ((n_checked / 64) % 3 == 0) ? 0 : $urandom_range(13, 0);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            out_stall <= (rx_wait != 0) || (hold_left != 0);
        end
    end

    // Hold the output off once for a long stretch so the block backs up its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_checked >= 30) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
                 QUIET_LIMIT, ibd_expect.size());
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin : stimulus
        int unsigned k, n;

        // Directed: founders, homozygous and inbred parents, bad ids, restarts
        offer(1, 0, 0, 0, 0);
        offer(0, 0, 0, ALLELE_MAX, 5);
        offer(0, 1, 2, 0, ALLELE_MAX);
        offer(0, 3, 3, 0, ALLELE_MAX);
        offer(0, 5, 4, 1, 0);
        offer(0, ID_MAX, MAX_IND, 2, 3);
        offer(0, 1, 1, 0, 3);
        offer(0, 7, 2, 77, 5);
        offer(0, 0, 0, ALLELE_MAX, ALLELE_MAX);
        offer(1, 1, 0, 4, 4);
        offer(1, 0, 0, 10, 10);
        offer(0, 0, 0, 20, 30);
        offer(0, 2, 1, 20, 10);
        // father passes IBD through his own paternal allele
        offer(0, 0, 3, 5, 10);
        offer(0, 3, 0, ALLELE_MAX, 0);
        offer(0, 4, 4, 10, 10);

        // Random: mostly well-formed pedigrees, some noise bursts
        n = 0;
        while (n < RANDOM_ITEMS) begin
            idle_phase = $urandom_range(1, 0);
            if ($urandom_range(6, 0) == 0) begin
                repeat ($urandom_range(5, 1)) begin
                    add_noise();
                    n++;
                end
            end else begin
                k = $urandom_range(40, 2);
                add_member(1, 1);
                n++;
                repeat (k - 1) begin
                    if ($urandom_range(19, 0) == 0)
                        add_noise();
                    else
                        add_member(0, $urandom_range(4, 0) == 0);
                    n++;
                end
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_valid || ibd_expect.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d individuals over %0d pedigrees, %0d of them past a full store.",
                 n_sent, n_peds, n_full);
        $display("Checked %0d results: %0d order errors, %0d IBD alleles, %0d fully inbred.",
                 n_checked, n_order_err, n_ibd, n_inbred);
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
sv/pit_pkg.sv
sv/pit_ram.sv
sv/pit_parent.sv
sv/pedigree_ibd_tracker.sv
tb/tb_top.sv
